// ===== rtl/uvst_pkg.sv =====
// Shared types, constants and elaboration-time tables for the UV sphere tessellator.
// Used by uvst_front, uvst_queue, uvst_back and uv_sphere_tessellator_core.
package uvst_pkg;

   // Grid size and derived step counts
   localparam int SUBDIVISION = 16;
   localparam int STEPS       = 2 * SUBDIVISION;
   localparam int STEP_W      = $clog2(STEPS);

   // Field widths
   localparam int IDX_W    = 4;
   localparam int RADIUS_W = 16;
   localparam int COORD_W  = 17;
   localparam int TEX_W    = 17;
   localparam int SLOT_W   = 3;

   // Trig table entries are signed Q1.16, magnitudes at most one
   localparam int TRIG_FRAC = 16;
   localparam int TRIG_W    = TRIG_FRAC + 2;
   localparam int MAG_W     = TRIG_FRAC + 1;
   localparam int PROD1_W   = RADIUS_W + MAG_W;
   localparam int PROD2_W   = PROD1_W + MAG_W;

   // Vertex slots within a cell and their grid offsets (bit k belongs to slot k)
   localparam int VERTEX_COUNT               = 6;
   localparam logic [SLOT_W-1:0] FIRST_SLOT  = 3'd0;
   localparam logic [SLOT_W-1:0] LAST_SLOT   = 3'd5;
   localparam logic [VERTEX_COUNT-1:0] SLOT_LAT_STEP = 6'b101010;
   localparam logic [VERTEX_COUNT-1:0] SLOT_LON_STEP = 6'b011100;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd2560;
   localparam int QUEUE_DEPTH = 2;

   typedef longint unsigned u64_type;
   typedef longint          s64_type;

   localparam u64_type PI_Q30  = 64'd3373259426;
   localparam u64_type ONE_Q30 = 64'd1073741824;

   // Grid size and half of it as 64-bit constants for the table arithmetic
   localparam u64_type SUBDIV_U64      = u64_type'(SUBDIVISION);
   localparam u64_type SUBDIV_HALF_U64 = u64_type'(SUBDIVISION / 2);

   // One classified cell waiting for the vertex datapath
   typedef struct packed {
      logic [IDX_W-1:0] lat;
      logic [IDX_W-1:0] lon;
      logic [TEX_W-1:0] u0;
      logic [TEX_W-1:0] u1;
      logic [TEX_W-1:0] v0;
      logic [TEX_W-1:0] v1;
   } cell_type;

   // Next Taylor term: the previous term times x squared over the factorial step.
   function automatic u64_type next_term(u64_type term, u64_type x2, int n, bit cosine);
      u64_type p;
      p = term * x2;
      if (cosine) begin
         unique case (n)
            1: return p / 64'd2;
            2: return p / 64'd12;
            3: return p / 64'd30;
            4: return p / 64'd56;
            5: return p / 64'd90;
            6: return p / 64'd132;
            7: return p / 64'd182;
            8: return p / 64'd240;
            9: return p / 64'd306;
            default: return 64'd0;
         endcase
      end else begin
         unique case (n)
            1: return p / 64'd6;
            2: return p / 64'd20;
            3: return p / 64'd42;
            4: return p / 64'd72;
            5: return p / 64'd110;
            6: return p / 64'd156;
            7: return p / 64'd210;
            8: return p / 64'd272;
            9: return p / 64'd342;
            default: return 64'd0;
         endcase
      end
   endfunction

   // Sin or cos of m*pi/N as signed Q2.30, series through x^19 (sin) or x^18 (cos).
   function automatic s64_type series_q30(u64_type m, bit cosine);
      u64_type x;
      u64_type x2;
      u64_type term;
      s64_type sum;
      x    = (m * PI_Q30) / SUBDIV_U64;
      x2   = (x * x) >> 30;
      term = cosine ? ONE_Q30 : x;
      sum  = s64_type'(term);
      for (int n = 1; n <= 9; n++) begin
         term = next_term(term, x2, n, cosine);
         if ((n % 2) == 1) begin
            sum = sum - s64_type'(term);
         end else begin
            sum = sum + s64_type'(term);
         end
      end
      return sum;
   endfunction

   // Q2.30 to Q1.16, magnitude rounded half up and clamped to one.
   function automatic logic signed [TRIG_W-1:0] to_q16(s64_type s, bit neg_in);
      u64_type mag;
      bit      neg;
      neg = neg_in;
      if (s < 0) begin
         mag = u64_type'(-s);
         neg = !neg;
      end else begin
         mag = u64_type'(s);
      end
      mag = (mag + 64'd8192) >> 14;
      if (mag > 64'd65536) begin
         mag = 64'd65536;
      end
      return neg ? -TRIG_W'(mag) : TRIG_W'(mag);
   endfunction

   function automatic logic signed [TRIG_W-1:0] sin_q16(int k);
      int kk;
      bit neg;
      neg = 1'b0;
      kk  = k % STEPS;
      if (kk >= SUBDIVISION) begin
         kk  = kk - SUBDIVISION;
         neg = 1'b1;
      end
      if (2 * kk > SUBDIVISION) begin
         kk = SUBDIVISION - kk;
      end
      return to_q16(series_q30(u64_type'(kk), 1'b0), neg);
   endfunction

   function automatic logic signed [TRIG_W-1:0] cos_q16(int k);
      int kk;
      bit neg;
      neg = 1'b0;
      kk  = k % STEPS;
      if (kk >= SUBDIVISION) begin
         kk  = kk - SUBDIVISION;
         neg = 1'b1;
      end
      if (2 * kk > SUBDIVISION) begin
         kk  = SUBDIVISION - kk;
         neg = !neg;
      end
      return to_q16(series_q30(u64_type'(kk), 1'b1), neg);
   endfunction

   // num/N in Q.16, rounded half up
   function automatic logic [TEX_W-1:0] frac_q16(int num);
      return TEX_W'((u64_type'(num) * 64'd65536 + SUBDIV_HALF_U64) / SUBDIV_U64);
   endfunction

   localparam logic [TEX_W-1:0] TEX_ONE  = 17'd65536;
   localparam logic [TEX_W-1:0] TEX_STEP = frac_q16(1);

endpackage

// ===== rtl/uvst_front.sv =====
// Front end: takes cell commands, drops cells outside the grid and works out
// their texture coordinates. Depends on uvst_pkg.
module uvst_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [uvst_pkg::IDX_W-1:0]    req_lat_index,
   input  logic [uvst_pkg::IDX_W-1:0]    req_lon_index,
   output logic                          push_valid,
   output uvst_pkg::cell_type            push_cell,
   input  logic                          push_ready
);

   localparam int FracDepth = 2 ** uvst_pkg::IDX_W;

   logic [uvst_pkg::TEX_W-1:0] frac_rom [FracDepth];

   logic               hold_valid_ff, hold_valid_in;
   logic               hold_ok_ff, hold_ok_in;
   uvst_pkg::cell_type hold_cell_ff, hold_cell_in;

   logic               accept;
   logic               in_range;
   uvst_pkg::cell_type cell_new;

   // Table of index/N fractions, built at elaboration.
   for (genvar g = 0; g < FracDepth; g++) begin : g_frac_rom
      localparam logic [uvst_pkg::TEX_W-1:0] FracEntry = uvst_pkg::frac_q16(g);
      assign frac_rom[g] = FracEntry;
   end

   // The hold stage is busy only while it owns a valid cell the queue cannot take.
   assign busy       = hold_valid_ff && hold_ok_ff && !push_ready;
   assign accept     = start && !busy;
   assign push_valid = hold_valid_ff && hold_ok_ff;
   assign push_cell  = hold_cell_ff;

   // Classify the incoming cell and compute its texture corners.
   always_comb begin
      in_range      = (int'(req_lat_index) < uvst_pkg::SUBDIVISION) &&
                      (int'(req_lon_index) < uvst_pkg::SUBDIVISION);
      cell_new.lat  = req_lat_index;
      cell_new.lon  = req_lon_index;
      cell_new.u0   = frac_rom[req_lon_index];
      cell_new.u1   = frac_rom[req_lon_index] + uvst_pkg::TEX_STEP;
      cell_new.v0   = uvst_pkg::TEX_ONE - frac_rom[req_lat_index];
      cell_new.v1   = uvst_pkg::TEX_ONE - frac_rom[req_lat_index] + uvst_pkg::TEX_STEP;
   end

   // Hold stage next state: load on a transfer, empty once handed on or dropped.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_ok_in    = hold_ok_ff;
      hold_cell_in  = hold_cell_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_ok_in    = in_range;
         hold_cell_in  = cell_new;
      end else if (hold_valid_ff && (!hold_ok_ff || push_ready)) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         hold_ok_ff    <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         hold_ok_ff    <= hold_ok_in;
      end
      hold_cell_ff <= hold_cell_in;
   end

endmodule

// ===== rtl/uvst_queue.sv =====
// Short FIFO of classified cells between the front end and the vertex datapath.
// Depends on uvst_pkg.
module uvst_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  uvst_pkg::cell_type push_cell,
   output logic               push_ready,
   output logic               head_valid,
   output uvst_pkg::cell_type head_cell,
   input  logic               pop
);

   localparam int Depth = uvst_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   uvst_pkg::cell_type cells_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               push_fire;

   assign push_ready = (count_ff != CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_cell  = cells_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_fire) begin
         cells_ff[wr_ptr_ff] <= push_cell;
      end
   end

   // The datapath must never retire a cell from an empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

endmodule

// ===== rtl/uvst_back.sv =====
// Vertex datapath: walks the six vertex slots of the head cell, looks up the
// trig tables and scales by the radius over a four-stage pipeline. Depends on uvst_pkg.
module uvst_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [uvst_pkg::RADIUS_W-1:0]         radius,
   input  logic                                  head_valid,
   input  uvst_pkg::cell_type                    head_cell,
   output logic                                  pop,
   output logic                                  rsp_valid,
   output logic [uvst_pkg::SLOT_W-1:0]           rsp_vertex_slot,
   output logic signed [uvst_pkg::COORD_W-1:0]   rsp_pos_x,
   output logic signed [uvst_pkg::COORD_W-1:0]   rsp_pos_y,
   output logic signed [uvst_pkg::COORD_W-1:0]   rsp_pos_z,
   output logic [uvst_pkg::TEX_W-1:0]            rsp_tex_u,
   output logic [uvst_pkg::TEX_W-1:0]            rsp_tex_v,
   output logic                                  rsp_last
);

   localparam int Steps  = uvst_pkg::STEPS;
   localparam int StepW  = uvst_pkg::STEP_W;
   localparam int MagW   = uvst_pkg::MAG_W;
   localparam int P1W    = uvst_pkg::PROD1_W;
   localparam int P2W    = uvst_pkg::PROD2_W;
   localparam int CoordW = uvst_pkg::COORD_W;
   localparam int YShift = uvst_pkg::TRIG_FRAC;
   localparam int XShift = 2 * uvst_pkg::TRIG_FRAC;

   // Per-vertex data that rides along the whole pipeline
   typedef struct packed {
      logic [uvst_pkg::SLOT_W-1:0] slot;
      logic                        last;
      logic [uvst_pkg::TEX_W-1:0]  tex_u;
      logic [uvst_pkg::TEX_W-1:0]  tex_v;
      logic                        neg_x;
      logic                        neg_y;
      logic                        neg_z;
   } info_type;

   typedef struct packed {
      info_type          info;
      logic [MagW-1:0]   cl_mag;
      logic [MagW-1:0]   sl_mag;
      logic [MagW-1:0]   co_mag;
      logic [MagW-1:0]   so_mag;
   } lookup_type;

   typedef struct packed {
      info_type          info;
      logic [MagW-1:0]   co_mag;
      logic [MagW-1:0]   so_mag;
      logic [P1W-1:0]    ring_prod;
      logic [P1W-1:0]    y_prod;
   } scale_type;

   typedef struct packed {
      info_type          info;
      logic [P2W-1:0]    x_prod;
      logic [P2W-1:0]    z_prod;
      logic [CoordW-1:0] y_mag;
   } product_type;

   logic signed [uvst_pkg::TRIG_W-1:0] sin_rom [Steps];
   logic signed [uvst_pkg::TRIG_W-1:0] cos_rom [Steps];

   logic [uvst_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff, s2_valid_in;
   logic        s3_valid_ff, s3_valid_in;
   logic        out_valid_ff, out_valid_in;
   lookup_type  s1_ff, s1_in;
   scale_type   s2_ff, s2_in;
   product_type s3_ff, s3_in;

   logic [uvst_pkg::SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic signed [CoordW-1:0]    out_x_ff, out_x_in;
   logic signed [CoordW-1:0]    out_y_ff, out_y_in;
   logic signed [CoordW-1:0]    out_z_ff, out_z_in;
   logic [uvst_pkg::TEX_W-1:0]  out_u_ff, out_u_in;
   logic [uvst_pkg::TEX_W-1:0]  out_v_ff, out_v_in;
   logic                        out_last_ff, out_last_in;

   logic                  lat_step, lon_step;
   logic [StepW-1:0]      lat_idx;
   logic [StepW:0]        lon_sum;
   logic [StepW+1:0]      lon_dbl;
   logic [StepW-1:0]      lon_idx;
   logic signed [uvst_pkg::TRIG_W-1:0] cl, ca, co, so;
   logic [P2W:0]          x_round, z_round;
   logic [MagW-1:0]       x_mag, z_mag;
   logic [P1W:0]          y_round;

   // Sine and cosine tables over all 2N steps, built at elaboration.
   for (genvar g = 0; g < Steps; g++) begin : g_trig_rom
      localparam logic signed [uvst_pkg::TRIG_W-1:0] SinEntry = uvst_pkg::sin_q16(g);
      localparam logic signed [uvst_pkg::TRIG_W-1:0] CosEntry = uvst_pkg::cos_q16(g);
      assign sin_rom[g] = SinEntry;
      assign cos_rom[g] = CosEntry;
   end

   // Slot sequencer: one vertex per cycle while head_valid; cell popped on its last slot.
   always_comb begin
      slot_in = slot_ff;
      if (head_valid) begin
         slot_in = (slot_ff == uvst_pkg::LAST_SLOT) ? uvst_pkg::FIRST_SLOT : slot_ff + 1'b1;
      end
   end
   assign pop = head_valid && (slot_ff == uvst_pkg::LAST_SLOT);

   // Stage 1: grid point of this slot, table lookups, magnitudes and signs.
   always_comb begin
      lat_step = uvst_pkg::SLOT_LAT_STEP[slot_ff];
      lon_step = uvst_pkg::SLOT_LON_STEP[slot_ff];
      lat_idx  = StepW'(head_cell.lat) + StepW'(lat_step);
      lon_sum  = (StepW + 1)'(head_cell.lon) + (StepW + 1)'(lon_step);
      lon_dbl  = {lon_sum, 1'b0};
      if (lon_dbl >= (StepW + 2)'(Steps)) begin
         lon_dbl = lon_dbl - (StepW + 2)'(Steps);
      end
      lon_idx  = lon_dbl[StepW-1:0];

      cl = sin_rom[lat_idx];
      ca = cos_rom[lat_idx];
      co = cos_rom[lon_idx];
      so = sin_rom[lon_idx];

      s1_valid_in         = head_valid;
      s1_in.info.slot     = slot_ff;
      s1_in.info.last     = (slot_ff == uvst_pkg::LAST_SLOT);
      s1_in.info.tex_u    = lon_step ? head_cell.u1 : head_cell.u0;
      s1_in.info.tex_v    = lat_step ? head_cell.v0 : head_cell.v1;
      s1_in.info.neg_x    = cl[uvst_pkg::TRIG_W-1] ^ co[uvst_pkg::TRIG_W-1];
      s1_in.info.neg_z    = cl[uvst_pkg::TRIG_W-1] ^ so[uvst_pkg::TRIG_W-1];
      // y is minus the cosine of the step, so it is negative where the cosine is positive
      s1_in.info.neg_y    = !ca[uvst_pkg::TRIG_W-1] && (ca != '0);
      s1_in.cl_mag        = MagW'(cl[uvst_pkg::TRIG_W-1] ? -cl : cl);
      s1_in.sl_mag        = MagW'(ca[uvst_pkg::TRIG_W-1] ? -ca : ca);
      s1_in.co_mag        = MagW'(co[uvst_pkg::TRIG_W-1] ? -co : co);
      s1_in.so_mag        = MagW'(so[uvst_pkg::TRIG_W-1] ? -so : so);
   end

   // Stage 2: scale the ring radius and the height by the sphere radius.
   always_comb begin
      s2_valid_in     = s1_valid_ff;
      s2_in.info      = s1_ff.info;
      s2_in.co_mag    = s1_ff.co_mag;
      s2_in.so_mag    = s1_ff.so_mag;
      s2_in.ring_prod = P1W'(radius) * P1W'(s1_ff.cl_mag);
      s2_in.y_prod    = P1W'(radius) * P1W'(s1_ff.sl_mag);
   end

   // Stage 3: project the ring onto x and z; round the height.
   always_comb begin
      s3_valid_in  = s2_valid_ff;
      s3_in.info   = s2_ff.info;
      s3_in.x_prod = P2W'(s2_ff.ring_prod) * P2W'(s2_ff.co_mag);
      s3_in.z_prod = P2W'(s2_ff.ring_prod) * P2W'(s2_ff.so_mag);
      y_round      = {1'b0, s2_ff.y_prod} + (P1W + 1)'(1 << (YShift - 1));
      s3_in.y_mag  = CoordW'(y_round >> YShift);
   end

   // Stage 4: round x and z half away from zero, apply the signs.
   always_comb begin
      x_round      = {1'b0, s3_ff.x_prod} + (P2W + 1)'(64'd1 << (XShift - 1));
      z_round      = {1'b0, s3_ff.z_prod} + (P2W + 1)'(64'd1 << (XShift - 1));
      x_mag        = MagW'(x_round >> XShift);
      z_mag        = MagW'(z_round >> XShift);
      out_valid_in = s3_valid_ff;
      out_slot_in  = s3_ff.info.slot;
      out_last_in  = s3_ff.info.last;
      out_u_in     = s3_ff.info.tex_u;
      out_v_in     = s3_ff.info.tex_v;
      out_x_in     = s3_ff.info.neg_x ? -CoordW'(x_mag) : CoordW'(x_mag);
      out_z_in     = s3_ff.info.neg_z ? -CoordW'(z_mag) : CoordW'(z_mag);
      out_y_in     = s3_ff.info.neg_y ? -s3_ff.y_mag : s3_ff.y_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= uvst_pkg::FIRST_SLOT;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      out_slot_ff <= out_slot_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_z_ff    <= out_z_in;
      out_u_ff    <= out_u_in;
      out_v_ff    <= out_v_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_vertex_slot = out_slot_ff;
   assign rsp_pos_x       = out_x_ff;
   assign rsp_pos_y       = out_y_ff;
   assign rsp_pos_z       = out_z_ff;
   assign rsp_tex_u       = out_u_ff;
   assign rsp_tex_v       = out_v_ff;
   assign rsp_last        = out_last_ff;

   // The sequencer never runs past the last slot.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= uvst_pkg::LAST_SLOT)
      else $error("vertex slot counter out of range");

   // Vertices of one cell leave on consecutive cycles in slot order.
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=>
         (rsp_valid && (rsp_vertex_slot == $past(rsp_vertex_slot) + 1'b1)))
      else $error("vertex slots left out of order");

   // The last flag marks the final slot and no other.
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_vertex_slot == uvst_pkg::LAST_SLOT)))
      else $error("last flag does not match the final slot");

endmodule

// ===== rtl/uv_sphere_tessellator_core.sv =====
// Top level of the UV sphere tessellator, built from uvst_front, uvst_queue and uvst_back.
// A start transfer passes through the front-end hold register, the queue and the
// pipeline registers of the vertex datapath. Throughput: one vertex per cycle while
// cells are queued, set by the single vertex datapath that walks the six slots in turn;
// the front end can take new cells while it works on one. Results cannot be held off.
// Reset is synchronous: it empties the pipeline and the queue and sets the radius to 16'd2560.
module uv_sphere_tessellator_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [uvst_pkg::IDX_W-1:0]            req_lat_index,
   input  logic [uvst_pkg::IDX_W-1:0]            req_lon_index,
   output logic                                  rsp_valid,
   output logic [uvst_pkg::SLOT_W-1:0]           rsp_vertex_slot,
   output logic signed [uvst_pkg::COORD_W-1:0]   rsp_pos_x,
   output logic signed [uvst_pkg::COORD_W-1:0]   rsp_pos_y,
   output logic signed [uvst_pkg::COORD_W-1:0]   rsp_pos_z,
   output logic [uvst_pkg::TEX_W-1:0]            rsp_tex_u,
   output logic [uvst_pkg::TEX_W-1:0]            rsp_tex_v,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [uvst_pkg::RADIUS_W-1:0]         csr_radius
);

   logic [uvst_pkg::RADIUS_W-1:0] radius_ff, radius_in;

   logic               push_valid;
   logic               push_ready;
   uvst_pkg::cell_type push_cell;
   logic               head_valid;
   uvst_pkg::cell_type head_cell;
   logic               pop;

   // Radius register: a transfer on the register port replaces it.
   assign csr_ready = 1'b1;
   assign radius_in = (csr_valid && csr_ready) ? csr_radius : radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= uvst_pkg::RADIUS_RESET;
      end else begin
         radius_ff <= radius_in;
      end
   end

   uvst_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_lat_index (req_lat_index),
      .req_lon_index (req_lon_index),
      .push_valid    (push_valid),
      .push_cell     (push_cell),
      .push_ready    (push_ready)
   );

   uvst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cell  (push_cell),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_cell  (head_cell),
      .pop        (pop)
   );

   uvst_back u_back (
      .clock           (clock),
      .reset           (reset),
      .radius          (radius_ff),
      .head_valid      (head_valid),
      .head_cell       (head_cell),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_vertex_slot (rsp_vertex_slot),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_last        (rsp_last)
   );

endmodule
